// ===== hw/rtl/cmg_pkg.sv =====
// Shared types, widths and codes for the clock map and monotonic guard.
`timescale 1ns / 1ps

package cmg_pkg;

   // Fixed-point and epoch configuration.
   localparam int RATE_FRAC_BITS = 32;
   localparam int EPOCH_BITS     = 32;

   // Field widths.
   localparam int TIME_W     = 64;
   localparam int SEQ_W      = 64;
   localparam int RATE_W     = 48;
   localparam int EPOCH_ID_W = 32;
   localparam int VERDICT_W  = 3;

   // Partial product split of the mapping multiply.
   localparam int MAG_LO_W  = 32;
   localparam int MAG_HI_W  = TIME_W - MAG_LO_W;
   localparam int RATE_LO_W = 32;
   localparam int RATE_HI_W = RATE_W - RATE_LO_W;
   localparam int MID_W     = MAG_LO_W + RATE_LO_W + 1;
   localparam int PROD_W    = TIME_W + RATE_W;

   // Signed sum of anchor and scaled delta, and its rounded integer part.
   localparam int BASE_W = TIME_W + RATE_FRAC_BITS;
   localparam int SUM_W  = (((PROD_W + 1) > BASE_W) ? (PROD_W + 1) : BASE_W) + 1;
   localparam int Q_W    = SUM_W - RATE_FRAC_BITS;

   // Rate register reset value, a ratio of 1.0 in Q16.32.
   localparam logic [RATE_W-1:0] RATE_RESET = 48'h0001_0000_0000;

   // Register port geometry: 64-bit registers at 8-byte strides.
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_LSB    = 3;
   localparam int CSR_ADDR_W = CSR_IDX_W + CSR_LSB;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RAW_REF     = 3'd0,
      CSR_FUSION_REF  = 3'd1,
      CSR_RATE        = 3'd2,
      CSR_MODEL_OK    = 3'd3,
      CSR_EPOCH       = 3'd4,
      CSR_UNCERTAINTY = 3'd5,
      CSR_DISCONT     = 3'd6
   } csr_index_type;

   typedef enum logic [VERDICT_W-1:0] {
      VERDICT_ADMITTED      = 3'd0,
      VERDICT_INVALID_MODEL = 3'd1,
      VERDICT_OVERFLOW      = 3'd2,
      VERDICT_INVALID_STAMP = 3'd3,
      VERDICT_EPOCH_CHANGED = 3'd4,
      VERDICT_RAW_NONMONO   = 3'd5,
      VERDICT_FUSION_NONMONO = 3'd6,
      VERDICT_INGRESS_NONMONO = 3'd7
   } verdict_type;

   // Current clock model as held in the register file.
   typedef struct packed {
      logic [TIME_W-1:0]     raw_anchor;
      logic [TIME_W-1:0]     fus_anchor;
      logic [RATE_W-1:0]     rate_q32;
      logic                  model_ok;
      logic [EPOCH_ID_W-1:0] epoch_id;
      logic [TIME_W-1:0]     uncertainty_ns;
      logic                  discontinuous;
   } cfg_type;

   // One mapped item handed from the mapping pipeline to the guard.
   typedef struct packed {
      logic [TIME_W-1:0] raw_stamp;
      logic [SEQ_W-1:0]  ingress_seq;
      logic              ingress_ok;
      logic [TIME_W-1:0] mapped_time;
      logic              overflow;
   } map_item_type;

endpackage

// ===== hw/rtl/clock_map_and_monotonic_guard_unit.sv =====
// Top level of the clock map and monotonic guard.
`timescale 1ns / 1ps

//  Channel   Ports                                          Direction  Handshake
//  request   req_raw_stamp, req_ingress_seq, req_ingress_ok in         req_valid / req_ready
//  response  rsp_mapped_time, rsp_verdict                   out        rsp_valid / rsp_ready
//  config    csr_psel .. csr_prdata, 8-byte stride          in/out     APB, csr_pready high
//
//  One item per cycle sustained while rsp_ready is high; each accepted item passes the input register,
//  five mapping stages around the 64x48 multiply, rounding and the result register in turn.
//  Reset is synchronous and active high; it clears the pipeline, the guard history and
//  the clock model registers. With rsp_ready low, bubbles in the pipeline close up and
//  req_ready falls only once all eight registers hold an item.

module clock_map_and_monotonic_guard_unit
   import cmg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [TIME_W-1:0]     req_raw_stamp,
   input  logic [SEQ_W-1:0]      req_ingress_seq,
   input  logic                  req_ingress_ok,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [TIME_W-1:0]     rsp_mapped_time,
   output logic [VERDICT_W-1:0]  rsp_verdict,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type      cfg;
   logic         map_valid;
   logic         map_ready;
   map_item_type map_item;

   // Clock model registers.
   cmg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Raw to mapped time pipeline.
   cmg_map u_map (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_raw_stamp   (req_raw_stamp),
      .req_ingress_seq (req_ingress_seq),
      .req_ingress_ok  (req_ingress_ok),
      .map_valid       (map_valid),
      .map_ready       (map_ready),
      .map_item        (map_item)
   );

   // Guard and result register.
   cmg_guard u_guard (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .map_valid       (map_valid),
      .map_ready       (map_ready),
      .map_item        (map_item),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_mapped_time (rsp_mapped_time),
      .rsp_verdict     (rsp_verdict)
   );

endmodule

// ===== hw/rtl/cmg_csr.sv =====
// Register file and APB-style access port for the clock model.
`timescale 1ns / 1ps

module cmg_csr
   import cmg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   logic          wr_en;
   csr_index_type idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign idx        = csr_index_type'(csr_paddr[CSR_ADDR_W-1:CSR_LSB]);
   assign cfg        = cfg_ff;

   // Register writes on the access phase; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.raw_anchor       <= '0;
         cfg_ff.fus_anchor       <= '0;
         cfg_ff.rate_q32         <= RATE_RESET;
         cfg_ff.model_ok         <= 1'b0;
         cfg_ff.epoch_id         <= '0;
         cfg_ff.uncertainty_ns   <= '0;
         cfg_ff.discontinuous    <= 1'b0;
      end else if (wr_en) begin
         case (idx)
            CSR_RAW_REF:     cfg_ff.raw_anchor       <= csr_pwdata[TIME_W-1:0];
            CSR_FUSION_REF:  cfg_ff.fus_anchor       <= csr_pwdata[TIME_W-1:0];
            CSR_RATE:        cfg_ff.rate_q32         <= csr_pwdata[RATE_W-1:0];
            CSR_MODEL_OK:    cfg_ff.model_ok         <= csr_pwdata[0];
            CSR_EPOCH:       cfg_ff.epoch_id         <= csr_pwdata[EPOCH_ID_W-1:0];
            CSR_UNCERTAINTY: cfg_ff.uncertainty_ns   <= csr_pwdata[TIME_W-1:0];
            CSR_DISCONT:     cfg_ff.discontinuous    <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // Read data, zero-extended to the port width.
   always_comb begin
      case (idx)
         CSR_RAW_REF:     csr_prdata = cfg_ff.raw_anchor;
         CSR_FUSION_REF:  csr_prdata = cfg_ff.fus_anchor;
         CSR_RATE:        csr_prdata = CSR_DATA_W'(cfg_ff.rate_q32);
         CSR_MODEL_OK:    csr_prdata = CSR_DATA_W'(cfg_ff.model_ok);
         CSR_EPOCH:       csr_prdata = CSR_DATA_W'(cfg_ff.epoch_id);
         CSR_UNCERTAINTY: csr_prdata = cfg_ff.uncertainty_ns;
         CSR_DISCONT:     csr_prdata = CSR_DATA_W'(cfg_ff.discontinuous);
         default:         csr_prdata = '0;
      endcase
   end

endmodule

// ===== hw/rtl/cmg_map.sv =====
// Pipelined affine time mapping with round-half-away and overflow detection.
`timescale 1ns / 1ps

module cmg_map
   import cmg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [TIME_W-1:0] req_raw_stamp,
   input  logic [SEQ_W-1:0]  req_ingress_seq,
   input  logic              req_ingress_ok,
   output logic              map_valid,
   input  logic              map_ready,
   output map_item_type      map_item
);

   localparam int NUM_STAGES = 7;

   typedef struct packed {
      logic [TIME_W-1:0] raw_stamp;
      logic [SEQ_W-1:0]  ingress_seq;
      logic              ingress_ok;
   } pass_type;

   localparam logic [SUM_W-1:0] ROUND_UP = SUM_W'(1) << (RATE_FRAC_BITS - 1);
   localparam logic [SUM_W-1:0] ROUND_DN = ROUND_UP - SUM_W'(1);

   // Stage valid bits and per-stage advance enables.
   logic [NUM_STAGES:1] v_ff;
   logic [NUM_STAGES:1] en;

   // Stage payloads.
   pass_type p1_ff, p2_ff, p3_ff, p4_ff, p5_ff, p6_ff, p7_ff;
   logic     dneg2_ff, dneg3_ff, dneg4_ff, dneg5_ff;

   logic [TIME_W-1:0]              mag2_ff, mag2_in;
   logic                           dneg2_in;
   logic [TIME_W:0]                diff_pos, diff_neg;
   logic [MAG_LO_W+RATE_LO_W-1:0]  pp00_ff, pp00_in;
   logic [MAG_LO_W+RATE_HI_W-1:0]  pp01_ff, pp01_in;
   logic [MAG_HI_W+RATE_LO_W-1:0]  pp10_ff, pp10_in;
   logic [MAG_HI_W+RATE_HI_W-1:0]  pp11_ff, pp11_in;
   logic [PROD_W-1:0]              outer4_ff;
   logic [MID_W-1:0]               mid4_ff, mid4_in;
   logic [PROD_W-1:0]              prod5_ff, prod5_in;
   logic [SUM_W-1:0]               prod_ext, base, sum6_ff, sum6_in;
   logic [SUM_W-1:0]               rounded;
   logic [Q_W-1:0]                 q_val;
   logic [TIME_W-1:0]              fus7_ff;
   logic                           ovf7_ff, ovf7_in;

   function automatic logic [TIME_W:0] req_sx(input logic [TIME_W-1:0] v);
      req_sx = {v[TIME_W-1], v};
   endfunction

   // Backward enable chain: a stage moves when it is empty or its successor moves.
   always_comb begin
      en[NUM_STAGES] = !v_ff[NUM_STAGES] || map_ready;
      for (int k = NUM_STAGES - 1; k >= 1; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign req_ready = en[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[1]) begin
            v_ff[1] <= req_valid;
         end
         for (int k = 2; k <= NUM_STAGES; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // Signed distance from the raw anchor, split into magnitude and sign.
   assign diff_pos = {req_sx(p1_ff.raw_stamp)} - {req_sx(cfg.raw_anchor)};
   assign diff_neg = {req_sx(cfg.raw_anchor)} - {req_sx(p1_ff.raw_stamp)};
   assign dneg2_in = diff_pos[TIME_W];
   assign mag2_in  = dneg2_in ? diff_neg[TIME_W-1:0] : diff_pos[TIME_W-1:0];

   // Four partial products of magnitude times rate.
   assign pp00_in = mag2_ff[MAG_LO_W-1:0] * cfg.rate_q32[RATE_LO_W-1:0];
   assign pp01_in = mag2_ff[MAG_LO_W-1:0] * cfg.rate_q32[RATE_W-1:RATE_LO_W];
   assign pp10_in = mag2_ff[TIME_W-1:MAG_LO_W] * cfg.rate_q32[RATE_LO_W-1:0];
   assign pp11_in = mag2_ff[TIME_W-1:MAG_LO_W] * cfg.rate_q32[RATE_W-1:RATE_LO_W];

   // Middle cross terms summed; outer terms do not overlap and concatenate.
   assign mid4_in  = MID_W'(pp01_ff) + MID_W'(pp10_ff);
   assign prod5_in = outer4_ff + (PROD_W'(mid4_ff) << MAG_LO_W);

   // Anchor in fixed point plus the signed scaled delta, negation by carry-in.
   assign base     = {{(SUM_W - BASE_W){cfg.fus_anchor[TIME_W-1]}},
                      cfg.fus_anchor, {RATE_FRAC_BITS{1'b0}}};
   assign prod_ext = SUM_W'(prod5_ff);
   assign sum6_in  = base + (dneg5_ff ? ~prod_ext : prod_ext) + SUM_W'(dneg5_ff);

   // Round half away from zero: add one half less an ulp for negative sums,
   // then keep the integer part by arithmetic truncation.
   assign rounded = sum6_ff + (sum6_ff[SUM_W-1] ? ROUND_DN : ROUND_UP);
   assign q_val   = rounded[SUM_W-1:RATE_FRAC_BITS];
   assign ovf7_in = !((&q_val[Q_W-1:TIME_W-1]) || !(|q_val[Q_W-1:TIME_W-1]));

   // Stage payload registers.
   always_ff @(posedge clock) begin
      if (en[1]) begin
         p1_ff <= {req_raw_stamp, req_ingress_seq, req_ingress_ok};
      end
      if (en[2]) begin
         p2_ff    <= p1_ff;
         mag2_ff  <= mag2_in;
         dneg2_ff <= dneg2_in;
      end
      if (en[3]) begin
         p3_ff    <= p2_ff;
         dneg3_ff <= dneg2_ff;
         pp00_ff  <= pp00_in;
         pp01_ff  <= pp01_in;
         pp10_ff  <= pp10_in;
         pp11_ff  <= pp11_in;
      end
      if (en[4]) begin
         p4_ff     <= p3_ff;
         dneg4_ff  <= dneg3_ff;
         outer4_ff <= {pp11_ff, pp00_ff};
         mid4_ff   <= mid4_in;
      end
      if (en[5]) begin
         p5_ff    <= p4_ff;
         dneg5_ff <= dneg4_ff;
         prod5_ff <= prod5_in;
      end
      if (en[6]) begin
         p6_ff   <= p5_ff;
         sum6_ff <= sum6_in;
      end
      if (en[7]) begin
         p7_ff   <= p6_ff;
         fus7_ff <= q_val[TIME_W-1:0];
         ovf7_ff <= ovf7_in;
      end
   end

   assign map_valid            = v_ff[NUM_STAGES];
   assign map_item.raw_stamp   = p7_ff.raw_stamp;
   assign map_item.ingress_seq = p7_ff.ingress_seq;
   assign map_item.ingress_ok  = p7_ff.ingress_ok;
   assign map_item.mapped_time = fus7_ff;
   assign map_item.overflow    = ovf7_ff;

endmodule

// ===== hw/rtl/cmg_guard.sv =====
// Monotonic guard with last admitted stamp and the result register.
`timescale 1ns / 1ps

module cmg_guard
   import cmg_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  logic                 map_valid,
   output logic                 map_ready,
   input  map_item_type         map_item,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [TIME_W-1:0]    rsp_mapped_time,
   output logic [VERDICT_W-1:0] rsp_verdict
);

   logic                  take;
   logic [EPOCH_BITS-1:0] epoch;
   verdict_type           verdict_in, verdict_ff;
   logic [TIME_W-1:0]     fus_in, fus_ff;
   logic                  rsp_valid_ff;

   // Last admitted stamp.
   logic                  has_last_ff;
   logic [EPOCH_BITS-1:0] last_epoch_ff;
   logic [TIME_W-1:0]     last_raw_ff;
   logic [TIME_W-1:0]     last_fusion_ff;
   logic [SEQ_W-1:0]      last_ingress_ff;

   assign map_ready = !rsp_valid_ff || rsp_ready;
   assign take      = map_valid && map_ready;
   assign epoch     = EPOCH_BITS'(cfg.epoch_id);

   // Ordered checks: the first failing one sets the verdict.
   always_comb begin
      if (!cfg.model_ok || !map_item.ingress_ok) begin
         verdict_in = VERDICT_INVALID_MODEL;
      end else if (map_item.overflow) begin
         verdict_in = VERDICT_OVERFLOW;
      end else if (cfg.uncertainty_ns[TIME_W-1] || cfg.discontinuous) begin
         verdict_in = VERDICT_INVALID_STAMP;
      end else if (has_last_ff && (epoch != last_epoch_ff)) begin
         verdict_in = VERDICT_EPOCH_CHANGED;
      end else if (has_last_ff &&
                   !($signed(last_raw_ff) < $signed(map_item.raw_stamp))) begin
         verdict_in = VERDICT_RAW_NONMONO;
      end else if (has_last_ff &&
                   !($signed(last_fusion_ff) < $signed(map_item.mapped_time))) begin
         verdict_in = VERDICT_FUSION_NONMONO;
      end else if (has_last_ff && (map_item.ingress_seq <= last_ingress_ff)) begin
         verdict_in = VERDICT_INGRESS_NONMONO;
      end else begin
         verdict_in = VERDICT_ADMITTED;
      end
   end

   // Mapping errors report a zero time.
   assign fus_in = ((verdict_in == VERDICT_INVALID_MODEL) ||
                    (verdict_in == VERDICT_OVERFLOW)) ? '0 : map_item.mapped_time;

   // Output register and guard state; the state moves only on admission.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         has_last_ff  <= 1'b0;
      end else begin
         if (map_ready) begin
            rsp_valid_ff <= map_valid;
         end
         if (take && (verdict_in == VERDICT_ADMITTED)) begin
            has_last_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         verdict_ff <= verdict_in;
         fus_ff     <= fus_in;
         if (verdict_in == VERDICT_ADMITTED) begin
            last_epoch_ff   <= epoch;
            last_raw_ff     <= map_item.raw_stamp;
            last_fusion_ff  <= map_item.mapped_time;
            last_ingress_ff <= map_item.ingress_seq;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_mapped_time = fus_ff;
   assign rsp_verdict     = verdict_ff;

endmodule
